// ===== sv/p2pa_pkg.sv =====
// ----------------------------------------------------------------------------
// p2pa_pkg
// Shared codes and field widths of the power-of-two page allocator.
// ----------------------------------------------------------------------------
package p2pa_pkg;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 16;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 13;
    localparam int RPAGES_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_HEAD  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;

endpackage

// ===== sv/power_of_two_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// power_of_two_page_allocator_top
// Power-of-two page allocator with one LIFO free list per size class.
// ----------------------------------------------------------------------------
// The input channel (s_) carries one request per beat: allocate, free, rebuild
// or no operation. The result channel (m_) returns exactly one beat per
// request with a status, the allocated address and the total of free pages.
// The configuration channel writes the range start and length, which take
// effect at the next rebuild; it is always ready.
// Per-page links and class marks live in two synchronous RAMs.
// A no operation or a request rejected at once goes straight to its result;
// a free first reads the page's class mark and then checks it. An allocation
// reads the chosen list head, splits the block down one class at a time until
// it reaches the class asked for, then pops that head. A rebuild plans the
// carving one class at a time, sweeps the page table one entry a cycle, then loads the result.
// The input is ready again in the cycle after a result is loaded.
// After reset the same sweep clears the class marks; no request is taken until it ends.
// A finished result waits in an output register while the receiver stalls;
// a new request is taken meanwhile, but its result is held back until the
// output register is free.
// ----------------------------------------------------------------------------
module power_of_two_page_allocator_top #(
    parameter int MAX_PAGES   = 4096,
    parameter int NUM_CLASSES = 11,
    parameter int PAGE_BITS   = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [p2pa_pkg::OP_W-1:0]           s_op,
    input  logic [p2pa_pkg::COUNT_W-1:0]        s_page_count,
    input  logic [p2pa_pkg::ADDR_W-1:0]         s_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [p2pa_pkg::STATUS_W-1:0]       m_status,
    output logic [p2pa_pkg::ADDR_W-1:0]         m_block_address,
    output logic [p2pa_pkg::FREE_W-1:0]         m_free_pages,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [p2pa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p2pa_pkg::ADDR_W-1:0]         cfg_data
);

    localparam int PW  = $clog2(MAX_PAGES);
    localparam int PCW = PW + 1;
    localparam int KW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int MW  = $clog2(NUM_CLASSES + 1);
    localparam int XW  = (PCW > p2pa_pkg::RPAGES_W) ? PCW : p2pa_pkg::RPAGES_W;
    localparam logic [MW-1:0] MARK_NONE = MW'(NUM_CLASSES);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SWEEP, S_RD, S_SPL1, S_SPL2, S_POP,
        S_FRA, S_FCHK, S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [p2pa_pkg::ADDR_W-1:0]   range_start_reg;
    logic [p2pa_pkg::RPAGES_W-1:0] range_pages_reg;
    logic [p2pa_pkg::ADDR_W-1:0]   pool_start_reg;
    logic [PCW-1:0]                pool_pages_reg;

    logic [PW-1:0]  head_reg  [NUM_CLASSES];
    logic [PCW-1:0] count_reg [NUM_CLASSES];
    logic [PCW-1:0] rstart_reg [NUM_CLASSES];
    logic [PCW-1:0] rend_reg   [NUM_CLASSES];
    logic [PCW-1:0] total_reg;

    logic [PCW-1:0] rem_reg, base_reg;
    logic           broken_reg;
    logic [KW-1:0]  kk_reg, j_reg, k_reg;
    logic [PW-1:0]  p_reg, lo_reg, idx_reg;
    logic           rebuild_reg;

    logic [p2pa_pkg::STATUS_W-1:0] res_status_reg;
    logic [p2pa_pkg::ADDR_W-1:0]   res_addr_reg;

    logic                          m_valid_reg;
    logic [p2pa_pkg::STATUS_W-1:0] m_status_reg;
    logic [p2pa_pkg::ADDR_W-1:0]   m_addr_reg;
    logic [p2pa_pkg::FREE_W-1:0]   m_free_reg;

    logic [PW-1:0]   link_mem [MAX_PAGES];
    logic [MW:0]     mark_mem [MAX_PAGES];
    logic [PW-1:0]   link_q;
    logic [MW:0]     mark_q;

    logic            link_we, mark_we;
    logic [PW-1:0]   link_waddr, link_raddr, mark_waddr, mark_raddr;
    logic [PW-1:0]   link_wdata;
    logic [MW:0]     mark_wdata;

    logic            accept;
    logic [16:0]     cnt;
    logic            too_big, found;
    logic [KW-1:0]   kneed, jsel;
    logic [p2pa_pkg::ADDR_W-1:0] diff;
    logic            outside;
    logic            hit;
    logic [KW-1:0]   hit_k;
    logic [PCW-1:0]  p_ext;
    logic [PCW-1:0]  blk;
    logic [XW-1:0]   pages_ext;
    logic [PW-1:0]   hi_page;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_block_address = m_addr_reg;
    assign m_free_pages    = m_free_reg;

    always_comb begin
        cnt = (s_page_count == '0) ? 17'd1 : {1'b0, s_page_count};
        too_big = cnt > (17'd1 << (NUM_CLASSES - 1));
        kneed = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ((17'd1 << k) >= cnt) begin
                kneed = KW'(k);
            end
        end
        found = 1'b0;
        jsel  = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (KW'(k) >= kneed && count_reg[k] != '0) begin
                found = 1'b1;
                jsel  = KW'(k);
            end
        end
        diff = s_address - pool_start_reg;
        outside = (s_address < pool_start_reg) ||
                  ((diff >> PAGE_BITS) >= p2pa_pkg::ADDR_W'(pool_pages_reg));
        p_ext = PCW'(p_reg);
        hit   = 1'b0;
        hit_k = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (p_ext >= rstart_reg[k] && p_ext < rend_reg[k] &&
                    ((p_ext & ((PCW'(1) << k) - PCW'(1))) == '0)) begin
                hit   = 1'b1;
                hit_k = KW'(k);
            end
        end
        blk = (rem_reg >> kk_reg) << kk_reg;
        pages_ext = XW'(range_pages_reg);
        if (pages_ext > XW'(MAX_PAGES)) begin
            pages_ext = XW'(MAX_PAGES);
        end
        hi_page = lo_reg + PW'((PCW'(1) << (j_reg - KW'(1))));
    end

    always_comb begin
        link_we    = 1'b0;
        mark_we    = 1'b0;
        link_waddr = p_reg;
        link_wdata = '0;
        mark_waddr = p_reg;
        mark_wdata = {1'b0, MARK_NONE};
        link_raddr = head_reg[j_reg];
        mark_raddr = idx_reg;
        case (state_reg)
            S_SWEEP: begin
                mark_we = 1'b1;
                if (hit) begin
                    link_we    = 1'b1;
                    link_wdata = head_reg[hit_k];
                    mark_wdata = {1'b1, MW'(hit_k)};
                end
            end
            S_SPL1: begin
                link_we    = 1'b1;
                mark_we    = 1'b1;
                link_waddr = head_reg[j_reg];
                mark_waddr = head_reg[j_reg];
                link_wdata = head_reg[j_reg - KW'(1)];
                mark_wdata = {1'b1, MW'(j_reg - KW'(1))};
            end
            S_SPL2: begin
                link_we    = 1'b1;
                mark_we    = 1'b1;
                link_waddr = hi_page;
                mark_waddr = hi_page;
                link_wdata = lo_reg;
                mark_wdata = {1'b1, MW'(j_reg - KW'(1))};
            end
            S_POP: begin
                mark_we    = 1'b1;
                mark_waddr = head_reg[k_reg];
                mark_wdata = {1'b0, MW'(k_reg)};
            end
            S_FCHK: begin
                if (mark_q[MW-1:0] < MW'(NUM_CLASSES) && !mark_q[MW]) begin
                    link_we    = 1'b1;
                    mark_we    = 1'b1;
                    link_waddr = idx_reg;
                    mark_waddr = idx_reg;
                    link_wdata = head_reg[mark_q[KW-1:0]];
                    mark_wdata = {1'b1, mark_q[MW-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_q <= mark_mem[mark_raddr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_op)
                        p2pa_pkg::OP_ALLOC: begin
                            state_next = (too_big || !found) ? S_RESP : S_RD;
                        end
                        p2pa_pkg::OP_FREE: state_next = outside ? S_RESP : S_FRA;
                        p2pa_pkg::OP_REBUILD: state_next = S_PREP;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_PREP:  state_next = (kk_reg == '0) ? S_SWEEP : S_PREP;
            S_SWEEP: begin
                if (p_reg == '0) begin
                    state_next = rebuild_reg ? S_RESP : S_IDLE;
                end
            end
            S_RD:    state_next = (j_reg > k_reg) ? S_SPL1 : S_POP;
            S_SPL1:  state_next = S_SPL2;
            S_SPL2:  state_next = S_RD;
            S_POP:   state_next = S_RESP;
            S_FRA:   state_next = S_FCHK;
            S_FCHK:  state_next = S_RESP;
            S_RESP:  state_next = (!m_valid_reg || m_ready) ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            range_start_reg <= '0;
            range_pages_reg <= '0;
            pool_start_reg  <= '0;
            pool_pages_reg  <= '0;
            total_reg       <= '0;
            rebuild_reg     <= 1'b0;
            p_reg           <= PW'(MAX_PAGES - 1);
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                head_reg[k]   <= '0;
                count_reg[k]  <= '0;
                rstart_reg[k] <= '0;
                rend_reg[k]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == p2pa_pkg::CFG_RANGE_START) begin
                    range_start_reg <= cfg_data;
                end else if (cfg_index == p2pa_pkg::CFG_RANGE_PAGES) begin
                    range_pages_reg <= cfg_data[p2pa_pkg::RPAGES_W-1:0];
                end
            end
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    res_addr_reg <= '0;
                    if (accept && s_op == p2pa_pkg::OP_ALLOC && too_big) begin
                        res_status_reg <= p2pa_pkg::ST_TOO_BIG;
                    end else if (accept && s_op == p2pa_pkg::OP_ALLOC && !found) begin
                        res_status_reg <= p2pa_pkg::ST_NO_BLOCK;
                    end else if (accept && s_op == p2pa_pkg::OP_FREE && outside) begin
                        res_status_reg <= p2pa_pkg::ST_OUTSIDE;
                    end else begin
                        res_status_reg <= p2pa_pkg::ST_OK;
                    end
                    if (accept) begin
                        case (s_op)
                            p2pa_pkg::OP_ALLOC: begin
                                j_reg <= jsel;
                                k_reg <= kneed;
                            end
                            p2pa_pkg::OP_FREE: begin
                                idx_reg <= PW'(diff >> PAGE_BITS);
                            end
                            p2pa_pkg::OP_REBUILD: begin
                                rebuild_reg    <= 1'b1;
                                pool_start_reg <= range_start_reg;
                                pool_pages_reg <= PCW'(pages_ext);
                                rem_reg        <= PCW'(pages_ext);
                                base_reg       <= '0;
                                broken_reg     <= 1'b0;
                                kk_reg         <= KW'(NUM_CLASSES - 1);
                                p_reg          <= PW'(MAX_PAGES - 1);
                                total_reg      <= '0;
                                for (int k = 0; k < NUM_CLASSES; k++) begin
                                    head_reg[k]  <= '0;
                                    count_reg[k] <= '0;
                                end
                                rend_reg[0] <= PCW'(pages_ext);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    kk_reg <= kk_reg - KW'(1);
                    if (!broken_reg && kk_reg != '0 && blk != '0) begin
                        rstart_reg[kk_reg] <= base_reg;
                        rend_reg[kk_reg]   <= base_reg + blk;
                        base_reg <= base_reg + blk;
                        rem_reg  <= rem_reg - blk;
                    end else begin
                        if (kk_reg != '0) begin
                            rstart_reg[kk_reg] <= '0;
                            rend_reg[kk_reg]   <= '0;
                        end
                        if (!broken_reg) begin
                            rstart_reg[0] <= base_reg;
                            broken_reg    <= 1'b1;
                        end
                    end
                end
                S_SWEEP: begin
                    p_reg <= p_reg - PW'(1);
                    if (hit) begin
                        head_reg[hit_k]  <= p_reg;
                        count_reg[hit_k] <= count_reg[hit_k] + PCW'(1);
                        total_reg <= total_reg + (PCW'(1) << hit_k);
                    end
                end
                S_SPL1: begin
                    lo_reg           <= head_reg[j_reg];
                    head_reg[j_reg]  <= link_q;
                    count_reg[j_reg] <= count_reg[j_reg] - PCW'(1);
                end
                S_SPL2: begin
                    head_reg[j_reg - KW'(1)]  <= hi_page;
                    count_reg[j_reg - KW'(1)] <= count_reg[j_reg - KW'(1)] + PCW'(2);
                    j_reg <= j_reg - KW'(1);
                end
                S_POP: begin
                    head_reg[k_reg]  <= link_q;
                    count_reg[k_reg] <= count_reg[k_reg] - PCW'(1);
                    total_reg <= total_reg - (PCW'(1) << k_reg);
                    res_addr_reg <= pool_start_reg +
                        (p2pa_pkg::ADDR_W'(head_reg[k_reg]) << PAGE_BITS);
                end
                S_FCHK: begin
                    if (mark_q[MW-1:0] >= MW'(NUM_CLASSES)) begin
                        res_status_reg <= p2pa_pkg::ST_NOT_HEAD;
                    end else if (mark_q[MW]) begin
                        res_status_reg <= p2pa_pkg::ST_DBL_FREE;
                    end else begin
                        head_reg[mark_q[KW-1:0]]  <= idx_reg;
                        count_reg[mark_q[KW-1:0]] <= count_reg[mark_q[KW-1:0]] + PCW'(1);
                        total_reg <= total_reg + (PCW'(1) << mark_q[KW-1:0]);
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_addr_reg   <= res_addr_reg;
                        m_free_reg   <= p2pa_pkg::FREE_W'(total_reg);
                        rebuild_reg  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sim/allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocator_checker
// Watches the request, result and configuration channels of the page
// allocator, keeps its own copy of the free lists, predicts every result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module allocator_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [p2pa_pkg::OP_W-1:0]      s_op,
    input  logic [p2pa_pkg::COUNT_W-1:0]   s_page_count,
    input  logic [p2pa_pkg::ADDR_W-1:0]    s_address,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [p2pa_pkg::STATUS_W-1:0]  m_status,
    input  logic [p2pa_pkg::ADDR_W-1:0]    m_block_address,
    input  logic [p2pa_pkg::FREE_W-1:0]    m_free_pages,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [p2pa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [p2pa_pkg::ADDR_W-1:0]    cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam int NPAGES = 4096;
    localparam int NCLS   = 11;
    localparam int PBITS  = 12;
    localparam logic [3:0] NO_CLASS = 4'hF;

    typedef struct packed {
        logic [p2pa_pkg::STATUS_W-1:0] status;
        logic [p2pa_pkg::ADDR_W-1:0]   block_address;
        logic [p2pa_pkg::FREE_W-1:0]   free_pages;
    } alloc_result_t;

    alloc_result_t awaited_results[$];

    logic [31:0] cfg_start, pool_base;
    logic [12:0] cfg_pages, pool_len;
    logic [12:0] link_of[NPAGES];
    logic [3:0]  class_of[NPAGES];
    logic        is_free[NPAGES];
    logic [12:0] head_of[NCLS];
    int          count_of[NCLS];

    function automatic void push_page(int k, int pg);
        link_of[pg]  = head_of[k];
        head_of[k]   = pg[12:0];
        count_of[k]++;
        class_of[pg] = k[3:0];
        is_free[pg]  = 1'b1;
    endfunction

    function automatic int pop_page(int k);
        int pg;
        pg          = head_of[k];
        head_of[k]  = link_of[pg];
        count_of[k]--;
        is_free[pg] = 1'b0;
        return pg;
    endfunction

    function automatic void wipe_pool();
        for (int i = 0; i < NPAGES; i++) begin
            link_of[i]  = '0;
            class_of[i] = NO_CLASS;
            is_free[i]  = 1'b0;
        end
        for (int k = 0; k < NCLS; k++) begin
            head_of[k]  = '0;
            count_of[k] = 0;
        end
    endfunction

    function automatic void carve_pool();
        int left, base, n;
        wipe_pool();
        left = (cfg_pages > NPAGES) ? NPAGES : cfg_pages;
        pool_base = cfg_start;
        pool_len  = left[12:0];
        base = 0;
        for (int k = NCLS - 1; k >= 0 && left > 0; k--) begin
            n = left >> k;
            if (n > 0) begin
                for (int i = n - 1; i >= 0; i--) push_page(k, base + (i << k));
                base += n << k;
                left -= n << k;
            end else begin
                for (int i = left - 1; i >= 0; i--) push_page(0, base + i);
                break;
            end
        end
    endfunction

    function automatic alloc_result_t serve_request(logic [p2pa_pkg::OP_W-1:0] op,
                                                    logic [p2pa_pkg::COUNT_W-1:0] cnt_in,
                                                    logic [p2pa_pkg::ADDR_W-1:0] addr);
        alloc_result_t r;
        int cnt, k, j, lo, pg, sum;
        longint idx;
        r = '0;
        if (op == p2pa_pkg::OP_ALLOC) begin
            cnt = (cnt_in == 0) ? 1 : cnt_in;
            if (cnt > (1 << (NCLS - 1))) begin
                r.status = p2pa_pkg::ST_TOO_BIG;
            end else begin
                k = 0;
                while ((1 << k) < cnt) k++;
                j = k;
                while (j < NCLS && count_of[j] == 0) j++;
                if (j >= NCLS) begin
                    r.status = p2pa_pkg::ST_NO_BLOCK;
                end else begin
                    while (j > k) begin
                        lo = pop_page(j);
                        j--;
                        push_page(j, lo);
                        push_page(j, lo + (1 << j));
                    end
                    pg = pop_page(k);
                    r.block_address = pool_base + (pg << PBITS);
                end
            end
        end else if (op == p2pa_pkg::OP_FREE) begin
            if (addr < pool_base) begin
                r.status = p2pa_pkg::ST_OUTSIDE;
            end else begin
                idx = (longint'(addr) - longint'(pool_base)) >> PBITS;
                if (idx >= pool_len || idx >= NPAGES) r.status = p2pa_pkg::ST_OUTSIDE;
                else if (class_of[idx] >= NCLS) r.status = p2pa_pkg::ST_NOT_HEAD;
                else if (is_free[idx]) r.status = p2pa_pkg::ST_DBL_FREE;
                else push_page(class_of[idx], int'(idx));
            end
        end else if (op == p2pa_pkg::OP_REBUILD) begin
            carve_pool();
        end
        sum = 0;
        for (int c = 0; c < NCLS; c++) sum += count_of[c] << c;
        r.free_pages = sum[12:0];
        return r;
    endfunction

    assign pending = awaited_results.size();

    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            cfg_start  <= '0;
            cfg_pages  <= '0;
            pool_base  = '0;
            pool_len   = '0;
            fail_count <= 0;
            wipe_pool();
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == p2pa_pkg::CFG_RANGE_START) cfg_start <= cfg_data;
                else if (cfg_index == p2pa_pkg::CFG_RANGE_PAGES) cfg_pages <= cfg_data[12:0];
            end
            if (s_valid && s_ready)
                awaited_results.push_back(serve_request(s_op, s_page_count, s_address));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result status %0d address %h free %0d",
                             $time, m_status, m_block_address, m_free_pages);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== m_status || want.block_address !== m_block_address
                            || want.free_pages !== m_free_pages) begin
                        $display("%0t: expected status %0d address %h free %0d, got %0d %h %0d",
                                 $time, want.status, want.block_address, want.free_pages,
                                 m_status, m_block_address, m_free_pages);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the page allocator with directed and random requests and range
// settings, with random idling on both sides, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [p2pa_pkg::OP_W-1:0]      s_op = '0;
    logic [p2pa_pkg::COUNT_W-1:0]   s_page_count = '0;
    logic [p2pa_pkg::ADDR_W-1:0]    s_address = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [p2pa_pkg::STATUS_W-1:0]  m_status;
    logic [p2pa_pkg::ADDR_W-1:0]    m_block_address;
    logic [p2pa_pkg::FREE_W-1:0]    m_free_pages;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [p2pa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [p2pa_pkg::ADDR_W-1:0]    cfg_data = '0;
    int                             fail_count, pending;
    bit                             calm = 1'b0;
    bit                             hold_off = 1'b0;
    logic [31:0]                    cur_start;
    logic [12:0]                    cur_pages;
    logic [31:0]                    handed_out[$];

    power_of_two_page_allocator_top dut (.*);

    allocator_checker u_checker (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && (calm || $urandom_range(99) >= 14);
    end

    task automatic write_reg(logic [p2pa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send(logic [p2pa_pkg::OP_W-1:0] op, logic [p2pa_pkg::COUNT_W-1:0] cnt,
                        logic [p2pa_pkg::ADDR_W-1:0] addr);
        while (!calm && $urandom_range(99) < 14) @(posedge aclk);
        s_valid      <= 1'b1;
        s_op         <= op;
        s_page_count <= cnt;
        s_address    <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (4200) @(posedge aclk);
    endtask

    task automatic new_range(logic [31:0] start, logic [12:0] pages);
        drain();
        write_reg(p2pa_pkg::CFG_RANGE_START, start);
        write_reg(p2pa_pkg::CFG_RANGE_PAGES, {19'd0, pages});
        write_reg(p2pa_pkg::CFG_UNUSED, $urandom);
        cur_start = start;
        cur_pages = pages;
        handed_out.delete();
        send(p2pa_pkg::OP_REBUILD, 16'($urandom), $urandom);
    endtask

    task automatic random_item();
        int r;
        logic [31:0] a;
        r = $urandom_range(99);
        if (r < 45) begin
            send(p2pa_pkg::OP_ALLOC,
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                 $urandom);
            handed_out.push_back(cur_start + ($urandom_range(cur_pages) << 12));
        end else if (r < 85) begin
            if (handed_out.size() > 0 && $urandom_range(3) != 0) begin
                r = $urandom_range(handed_out.size() - 1);
                a = handed_out[r];
                handed_out.delete(r);
            end else if ($urandom_range(1)) begin
                a = cur_start + ($urandom_range(cur_pages + 2) << 12) + $urandom_range(4095);
            end else begin
                a = $urandom;
            end
            send(p2pa_pkg::OP_FREE, 16'($urandom), a);
        end else if (r < 97) begin
            send(p2pa_pkg::OP_NOP, 16'($urandom), $urandom);
        end else begin
            send(p2pa_pkg::OP_REBUILD, 16'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_start = '0;
        cur_pages = '0;
        send(p2pa_pkg::OP_ALLOC, '0, '0);
        send(p2pa_pkg::OP_FREE, '0, '0);
        new_range(32'h8000_0000, 13'd4096);
        send(p2pa_pkg::OP_ALLOC, 16'd0, '0);
        send(p2pa_pkg::OP_ALLOC, 16'd1024, '0);
        send(p2pa_pkg::OP_ALLOC, 16'd1025, '0);
        send(p2pa_pkg::OP_ALLOC, 16'hFFFF, '0);
        send(p2pa_pkg::OP_ALLOC, 16'd3, '0);
        send(p2pa_pkg::OP_FREE, '0, 32'h8000_0000);
        send(p2pa_pkg::OP_FREE, '0, 32'h8000_0000);
        send(p2pa_pkg::OP_FREE, '0, 32'h8040_0fff);
        send(p2pa_pkg::OP_FREE, '0, 32'h8000_1000);
        send(p2pa_pkg::OP_FREE, '0, 32'h7FFF_FFFF);
        send(p2pa_pkg::OP_FREE, '0, 32'h8100_0000);
        send(p2pa_pkg::OP_FREE, '0, 32'hFFFF_FFFF);
        send(p2pa_pkg::OP_NOP, '1, '1);
        new_range(32'hFFFF_F000, 13'h1FFF);
        send(p2pa_pkg::OP_ALLOC, 16'd1, '0);
        send(p2pa_pkg::OP_FREE, '0, 32'hFFFF_F000);
        new_range(32'h0001_3000, 13'd1000);
        for (int i = 0; i < 12; i++) send(p2pa_pkg::OP_ALLOC, 16'd1 << (i % 11), '0);
        for (int n = 0; n < 1100; n++) begin
            calm = (n >= 300 && n < 450);
            if (n == 600) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 700) begin
                while (pending != 0) @(posedge aclk);
            end
            if (n % 220 == 219) begin
                case ($urandom_range(3))
                    0: new_range($urandom & 32'hFFFF_F000, 13'($urandom_range(4096)));
                    1: new_range($urandom & 32'hFFFF_F000, 13'($urandom_range(64)));
                    2: new_range('0, 13'd0);
                    default: new_range(32'hFFFF_F000 - ($urandom_range(8) << 12), 13'd8191);
                endcase
            end
            random_item();
        end
        calm = 1'b1;
        drain();
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/p2pa_pkg.sv
sv/power_of_two_page_allocator_top.sv
sim/allocator_checker.sv
sim/testbench.sv
